// File: rtl/bcfp_pkg.sv
// ----------------------------------------------------------------------------
// bcfp_pkg
// Shared constants and character class helpers for the bracket command frame
// parser.
// ----------------------------------------------------------------------------
`default_nettype none

package bcfp_pkg;

    localparam int DEFAULT_MAX_FRAME_LEN = 64;

    localparam logic [7:0] CHAR_OPEN  = 8'h5B;  // '['
    localparam logic [7:0] CHAR_CLOSE = 8'h5D;  // ']'
    localparam logic [7:0] CHAR_COMMA = 8'h2C;  // ','
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;  // '+'
    localparam logic [7:0] CHAR_MINUS = 8'h2D;  // '-'
    localparam logic [7:0] CHAR_NUL   = 8'h00;

    // Magnitude ceiling of a number being read, and the signed limits.
    localparam logic [31:0] MAG_CAP   = 32'h8000_0000;
    localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;

    // Space, TAB, LF, VT, FF and CR count as white space.
    function automatic logic is_space(input logic [7:0] c);
        return (c == 8'h20) || ((c >= 8'h09) && (c <= 8'h0D));
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

endpackage

`default_nettype wire

// File: rtl/bracket_command_frame_parser.sv
// ----------------------------------------------------------------------------
// bracket_command_frame_parser
// Parses "[addr,value]" command frames from a byte stream and reports the
// held address and data values each time a frame closes.
// ----------------------------------------------------------------------------
// The block takes one received byte per beat on the s_ channel and returns one
// result beat on the m_ channel for every frame that closes with ']'; all other
// bytes produce no result. A byte is captured in an input register and is
// parsed from there by a single pass of logic that updates the
// frame state and, on a close, loads the result register, so the block
// sustains one byte per clock cycle but for the stall below. The only stall
// arises when a closing byte is ready to be parsed while the previous result
// still waits to be taken; other bytes keep flowing.
// Numbers are read like the scanf pattern "[%d,%d]": white space and a sign
// may precede each number, the comma must follow the first number directly,
// and values saturate at the 32-bit signed limits. A zero byte in a frame, or
// a frame longer than MAX_FRAME_LEN bytes counting both brackets, raises
// m_frame_error and leaves the held values unchanged.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_command_frame_parser
    import bcfp_pkg::*;
#(
    parameter int MAX_FRAME_LEN = DEFAULT_MAX_FRAME_LEN
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,

    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [7:0]         s_rx_byte,

    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic signed [31:0]      m_cmd_addr,
    output logic signed [31:0]      m_cmd_value,
    output logic                    m_addr_updated,
    output logic                    m_value_updated,
    output logic                    m_frame_error
);

    // The frame length counter must hold MAX_FRAME_LEN itself.
    localparam int LEN_W = $clog2(MAX_FRAME_LEN + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME_LEN);

    // Parse phases of the frame body.
    typedef enum logic [2:0] {
        PH_WS1   = 3'd0,  // white space before the first number
        PH_SIGN1 = 3'd1,  // sign of the first number seen
        PH_DIG1  = 3'd2,  // digits of the first number
        PH_WS2   = 3'd3,  // white space before the second number
        PH_SIGN2 = 3'd4,  // sign of the second number seen
        PH_DIG2  = 3'd5,  // digits of the second number
        PH_DONE  = 3'd6,  // match finished
        PH_FAIL  = 3'd7   // match failed before any number
    } phase_t;

    // Input register.
    logic             in_valid_reg;
    logic [7:0]       in_byte_reg;

    // Frame state.
    logic             in_frame_reg,   in_frame_next;
    logic [LEN_W-1:0] len_reg,        len_next;
    phase_t           phase_reg,      phase_next;
    logic             neg_reg,        neg_next;
    logic [31:0]      acc_reg,        acc_next;
    logic             digit_seen_reg, digit_seen_next;
    logic             bad_reg,        bad_next;
    logic [31:0]      first_reg,      first_next;
    logic [31:0]      held_addr_reg,  held_addr_next;
    logic [31:0]      held_value_reg, held_value_next;

    // Result register.
    logic             m_valid_reg;
    logic [31:0]      m_addr_reg;
    logic [31:0]      m_value_reg;
    logic             m_addr_upd_reg;
    logic             m_value_upd_reg;
    logic             m_err_reg;

    logic             upd_a;
    logic             upd_v;
    logic             err_v;
    logic             bad_v;
    logic             close_now;
    logic             advance;
    logic [35:0]      acc_prod;
    logic [31:0]      acc_digit;
    logic [31:0]      acc_first_digit;
    logic [31:0]      signed_val;

    // A closing byte inside a frame is the only byte that yields a result.
    assign close_now = in_valid_reg && in_frame_reg && (in_byte_reg == CHAR_CLOSE);

    // The parse stage moves on unless a result must be loaded into a full
    // result register that is not being drained this cycle.
    assign advance = in_valid_reg && (!close_now || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // Next accumulator after a digit: acc*10 + digit, saturating at 2^31.
    assign acc_prod = ({4'b0, acc_reg} << 3) + ({4'b0, acc_reg} << 1)
                      + {32'b0, in_byte_reg[3:0]};
    assign acc_digit = (acc_prod > {4'b0, MAG_CAP}) ? MAG_CAP : acc_prod[31:0];
    assign acc_first_digit = {28'b0, in_byte_reg[3:0]};

    // Signed value of the number being read, saturated to 32-bit signed.
    always_comb begin
        if (neg_reg) begin
            signed_val = (acc_reg >= MAG_CAP) ? MAG_CAP : (32'd0 - acc_reg);
        end else begin
            signed_val = (acc_reg >= MAG_CAP) ? POS_LIMIT : acc_reg;
        end
    end

    always_comb begin
        in_frame_next   = in_frame_reg;
        len_next        = len_reg;
        phase_next      = phase_reg;
        neg_next        = neg_reg;
        acc_next        = acc_reg;
        digit_seen_next = digit_seen_reg;
        bad_next        = bad_reg;
        first_next      = first_reg;
        held_addr_next  = held_addr_reg;
        held_value_next = held_value_reg;
        upd_a           = 1'b0;
        upd_v           = 1'b0;
        err_v           = 1'b0;
        bad_v           = bad_reg;

        if (in_byte_reg == CHAR_OPEN) begin
            in_frame_next   = 1'b1;
            len_next        = LEN_W'(1);
            phase_next      = PH_WS1;
            neg_next        = 1'b0;
            acc_next        = '0;
            digit_seen_next = 1'b0;
            bad_next        = 1'b0;
            first_next      = '0;
        end else if (in_frame_reg) begin
            if (len_reg >= LEN_MAX) begin
                bad_v = 1'b1;
            end else begin
                len_next = len_reg + LEN_W'(1);
            end

            if (in_byte_reg != CHAR_CLOSE) begin
                if (in_byte_reg == CHAR_NUL) begin
                    bad_v = 1'b1;
                end
                bad_next = bad_v;
                if (!bad_v) begin
                    case (phase_reg)
                        PH_WS1, PH_WS2: begin
                            if (!is_space(in_byte_reg)) begin
                                neg_next = (in_byte_reg == CHAR_MINUS);
                                acc_next = '0;
                                if ((in_byte_reg == CHAR_PLUS) ||
                                    (in_byte_reg == CHAR_MINUS)) begin
                                    phase_next = (phase_reg == PH_WS1) ? PH_SIGN1 : PH_SIGN2;
                                end else if (is_digit(in_byte_reg)) begin
                                    acc_next   = acc_first_digit;
                                    phase_next = (phase_reg == PH_WS1) ? PH_DIG1 : PH_DIG2;
                                end else begin
                                    digit_seen_next = 1'b0;
                                    phase_next = (phase_reg == PH_WS1) ? PH_FAIL : PH_DONE;
                                end
                            end
                        end
                        PH_SIGN1, PH_SIGN2: begin
                            if (is_digit(in_byte_reg)) begin
                                acc_next   = acc_digit;
                                phase_next = (phase_reg == PH_SIGN1) ? PH_DIG1 : PH_DIG2;
                            end else begin
                                digit_seen_next = 1'b0;
                                phase_next = (phase_reg == PH_SIGN1) ? PH_FAIL : PH_DONE;
                            end
                        end
                        PH_DIG1: begin
                            if (is_digit(in_byte_reg)) begin
                                acc_next = acc_digit;
                            end else begin
                                first_next = signed_val;
                                if (in_byte_reg == CHAR_COMMA) begin
                                    phase_next = PH_WS2;
                                end else begin
                                    digit_seen_next = 1'b0;
                                    phase_next      = PH_DONE;
                                end
                            end
                        end
                        PH_DIG2: begin
                            if (is_digit(in_byte_reg)) begin
                                acc_next = acc_digit;
                            end else begin
                                acc_next        = signed_val;
                                digit_seen_next = 1'b1;
                                phase_next      = PH_DONE;
                            end
                        end
                        default: begin
                            // Trailing bytes after a finished or failed match.
                        end
                    endcase
                end
            end else begin
                err_v = bad_v;
                if (!bad_v) begin
                    case (phase_reg)
                        PH_DIG1: begin
                            upd_a = 1'b1;
                            held_addr_next = signed_val;
                        end
                        PH_WS2, PH_SIGN2: begin
                            upd_a = 1'b1;
                            held_addr_next = first_reg;
                        end
                        PH_DIG2: begin
                            upd_a = 1'b1;
                            upd_v = 1'b1;
                            held_addr_next  = first_reg;
                            held_value_next = signed_val;
                        end
                        PH_DONE: begin
                            upd_a = 1'b1;
                            upd_v = digit_seen_reg;
                            held_addr_next = first_reg;
                            if (digit_seen_reg) begin
                                held_value_next = acc_reg;
                            end
                        end
                        default: begin
                            // No first number: nothing is updated.
                        end
                    endcase
                end
                in_frame_next   = 1'b0;
                len_next        = '0;
                phase_next      = PH_WS1;
                neg_next        = 1'b0;
                acc_next        = '0;
                digit_seen_next = 1'b0;
                bad_next        = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg   <= 1'b0;
            in_frame_reg   <= 1'b0;
            len_reg        <= '0;
            phase_reg      <= PH_WS1;
            neg_reg        <= 1'b0;
            acc_reg        <= '0;
            digit_seen_reg <= 1'b0;
            bad_reg        <= 1'b0;
            first_reg      <= '0;
            held_addr_reg  <= '0;
            held_value_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                in_frame_reg   <= in_frame_next;
                len_reg        <= len_next;
                phase_reg      <= phase_next;
                neg_reg        <= neg_next;
                acc_reg        <= acc_next;
                digit_seen_reg <= digit_seen_next;
                bad_reg        <= bad_next;
                first_reg      <= first_next;
                held_addr_reg  <= held_addr_next;
                held_value_reg <= held_value_next;
            end

            if (advance && close_now) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_byte_reg <= s_rx_byte;
        end
        if (advance && close_now) begin
            m_addr_reg      <= held_addr_next;
            m_value_reg     <= held_value_next;
            m_addr_upd_reg  <= upd_a;
            m_value_upd_reg <= upd_v;
            m_err_reg       <= err_v;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_cmd_addr      = m_addr_reg;
    assign m_cmd_value     = m_value_reg;
    assign m_addr_updated  = m_addr_upd_reg;
    assign m_value_updated = m_value_upd_reg;
    assign m_frame_error   = m_err_reg;

    // A pending result always shows the values held in the frame state, since
    // no later frame can close before it is taken.
    a_result_matches_held: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_addr_reg == held_addr_reg) && (m_value_reg == held_value_reg))
        else $error("pending result differs from held values");

    // An error frame never reports an update.
    a_error_no_update: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_err_reg |-> !m_addr_upd_reg && !m_value_upd_reg)
        else $error("error frame reported an update");

    // The data value is only stored together with the address.
    a_value_needs_addr: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && m_value_upd_reg |-> m_addr_upd_reg)
        else $error("value updated without address");

    // Outside a frame the parse state stays cleared.
    a_idle_state_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        !in_frame_reg |-> (len_reg == '0) && (phase_reg == PH_WS1) && !bad_reg)
        else $error("parse state not cleared outside a frame");

    // The frame length never runs past its limit.
    a_len_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        len_reg <= LEN_MAX)
        else $error("frame length beyond limit");

endmodule

`default_nettype wire

// File: bench/bcfp_scoreboard_pkg.sv
// ----------------------------------------------------------------------------
// bcfp_scoreboard_pkg
// Frame predictor and result store for the bracket command frame parser bench.
// ----------------------------------------------------------------------------
`default_nettype none

package bcfp_scoreboard_pkg;

    import bcfp_pkg::*;

    typedef enum logic [2:0] {
        SCAN_LEAD_A,
        SCAN_SIGN_A,
        SCAN_DIGITS_A,
        SCAN_LEAD_B,
        SCAN_SIGN_B,
        SCAN_DIGITS_B,
        SCAN_DONE,
        SCAN_FAILED
    } scan_state_t;

    typedef struct packed {
        logic signed [31:0] addr;
        logic signed [31:0] value;
        logic               addr_updated;
        logic               value_updated;
        logic               frame_error;
    } command_t;

    class frame_scoreboard;

        bit          frame_open;
        int unsigned length;
        scan_state_t state;
        bit          negative;
        logic [31:0] magnitude;
        bit          second_matched;
        logic [31:0] second_value;
        logic [31:0] first_value;
        bit          rejected;
        logic [31:0] held_addr;
        logic [31:0] held_value;

        command_t    expected_commands[$];
        int          mismatches;
        int          full_commands;
        int          addr_only;
        int          unmatched;
        int          rejects;

        function new();
            frame_open     = 1'b0;
            length         = 0;
            state          = SCAN_LEAD_A;
            negative       = 1'b0;
            magnitude      = '0;
            second_matched = 1'b0;
            second_value   = '0;
            first_value    = '0;
            rejected       = 1'b0;
            held_addr      = '0;
            held_value     = '0;
            mismatches     = 0;
            full_commands  = 0;
            addr_only      = 0;
            unmatched      = 0;
            rejects        = 0;
        endfunction

        function bit is_blank(logic [7:0] c);
            case (c)
                8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D, 8'h20: return 1'b1;
                default: return 1'b0;
            endcase
        endfunction

        function bit is_numeral(logic [7:0] c);
            return (c >= "0") && (c <= "9");
        endfunction

        // The magnitude sticks at 2^31 once it gets there.
        function void push_digit(logic [7:0] c);
            longint unsigned grown;
            grown = 64'(magnitude) * 64'd10 + 64'(c) - 64'h30;
            magnitude = (grown > 64'(MAG_CAP)) ? MAG_CAP : grown[31:0];
        endfunction

        function logic [31:0] clamped();
            if (magnitude >= MAG_CAP)
                return negative ? MAG_CAP : POS_LIMIT;
            return negative ? (32'd0 - magnitude) : magnitude;
        endfunction

        function void scan_char(logic [7:0] c);
            case (state)
                SCAN_LEAD_A, SCAN_LEAD_B: begin
                    if (is_blank(c))
                        return;
                    negative  = (c == CHAR_MINUS);
                    magnitude = '0;
                    if (c == CHAR_PLUS || c == CHAR_MINUS) begin
                        state = (state == SCAN_LEAD_A) ? SCAN_SIGN_A : SCAN_SIGN_B;
                    end else if (is_numeral(c)) begin
                        push_digit(c);
                        state = (state == SCAN_LEAD_A) ? SCAN_DIGITS_A : SCAN_DIGITS_B;
                    end else begin
                        second_matched = 1'b0;
                        state = (state == SCAN_LEAD_A) ? SCAN_FAILED : SCAN_DONE;
                    end
                end
                SCAN_SIGN_A, SCAN_SIGN_B: begin
                    if (is_numeral(c)) begin
                        push_digit(c);
                        state = (state == SCAN_SIGN_A) ? SCAN_DIGITS_A : SCAN_DIGITS_B;
                    end else begin
                        second_matched = 1'b0;
                        state = (state == SCAN_SIGN_A) ? SCAN_FAILED : SCAN_DONE;
                    end
                end
                SCAN_DIGITS_A: begin
                    if (is_numeral(c)) begin
                        push_digit(c);
                    end else begin
                        first_value = clamped();
                        if (c == CHAR_COMMA) begin
                            state = SCAN_LEAD_B;
                        end else begin
                            second_matched = 1'b0;
                            state = SCAN_DONE;
                        end
                    end
                end
                SCAN_DIGITS_B: begin
                    if (is_numeral(c)) begin
                        push_digit(c);
                    end else begin
                        second_value   = clamped();
                        second_matched = 1'b1;
                        state          = SCAN_DONE;
                    end
                end
                default: ;
            endcase
        endfunction

        // Called for every accepted byte; a closing bracket inside a frame queues one command.
        function void note_byte(logic [7:0] c);
            command_t cmd;
            if (c == CHAR_OPEN) begin
                frame_open     = 1'b1;
                length         = 1;
                state          = SCAN_LEAD_A;
                negative       = 1'b0;
                magnitude      = '0;
                second_matched = 1'b0;
                second_value   = '0;
                first_value    = '0;
                rejected       = 1'b0;
                return;
            end
            if (!frame_open)
                return;
            if (length >= DEFAULT_MAX_FRAME_LEN)
                rejected = 1'b1;
            else
                length++;
            if (c != CHAR_CLOSE) begin
                if (c == CHAR_NUL)
                    rejected = 1'b1;
                if (!rejected)
                    scan_char(c);
                return;
            end

            frame_open = 1'b0;
            cmd = '0;
            cmd.frame_error = rejected;
            if (!rejected) begin
                case (state)
                    SCAN_DIGITS_A: begin
                        first_value      = clamped();
                        cmd.addr_updated = 1'b1;
                    end
                    SCAN_LEAD_B, SCAN_SIGN_B: begin
                        cmd.addr_updated = 1'b1;
                    end
                    SCAN_DIGITS_B: begin
                        second_value      = clamped();
                        cmd.addr_updated  = 1'b1;
                        cmd.value_updated = 1'b1;
                    end
                    SCAN_DONE: begin
                        cmd.addr_updated  = 1'b1;
                        cmd.value_updated = second_matched;
                    end
                    default: ;
                endcase
                if (cmd.addr_updated)
                    held_addr = first_value;
                if (cmd.value_updated)
                    held_value = second_value;
            end
            cmd.addr  = held_addr;
            cmd.value = held_value;

            if (cmd.frame_error)
                rejects++;
            else if (cmd.value_updated)
                full_commands++;
            else if (cmd.addr_updated)
                addr_only++;
            else
                unmatched++;
            expected_commands.push_back(cmd);
        endfunction

        function void report(string field, logic [31:0] want, logic [31:0] got);
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR at %0t: %s expected %0d, got %0d",
                         $time, field, $signed(want), $signed(got));
        endfunction

        function void check_result(command_t got);
            command_t want;
            if (expected_commands.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"ERROR at %0t: result beat with no frame closed ",
                              "(addr %0d, value %0d)"},
                             $time, got.addr, got.value);
                return;
            end
            want = expected_commands.pop_front();
            if (got.addr !== want.addr)
                report("m_cmd_addr", want.addr, got.addr);
            if (got.value !== want.value)
                report("m_cmd_value", want.value, got.value);
            if (got.addr_updated !== want.addr_updated)
                report("m_addr_updated", 32'(want.addr_updated), 32'(got.addr_updated));
            if (got.value_updated !== want.value_updated)
                report("m_value_updated", 32'(want.value_updated), 32'(got.value_updated));
            if (got.frame_error !== want.frame_error)
                report("m_frame_error", 32'(want.frame_error), 32'(got.frame_error));
        endfunction

        function int pending();
            return expected_commands.size();
        endfunction

    endclass

endpackage

`default_nettype wire

// File: bench/bracket_command_frame_parser_test.sv
// ----------------------------------------------------------------------------
// bracket_command_frame_parser_test
// Self-checking bench for the bracket command frame parser. Byte streams of
// command frames, broken frames, overlong frames and loose bytes are pushed
// through the input channel while both sides idle at random, and every result
// beat is compared with a predictor that tracks the frame scan in parallel.
// ----------------------------------------------------------------------------
`default_nettype none

module bracket_command_frame_parser_test;

    timeunit 1ns;
    timeprecision 1ps;

    import bcfp_pkg::*;
    import bcfp_scoreboard_pkg::*;

    // Roughly this many bytes follow the directed opening.
    localparam int RANDOM_BYTES = 1550;
    localparam int CYCLE_LIMIT  = 400000;
    // The block answers through its input and result registers after the closing byte; leave some margin.
    localparam int DRAIN_CYCLES = 12;

    logic               aclk;
    logic               aresetn   = 1'b0;
    logic               s_valid   = 1'b0;
    logic               s_ready;
    logic [7:0]         s_rx_byte = 8'h00;
    logic               m_valid;
    logic               m_ready   = 1'b0;
    logic signed [31:0] m_cmd_addr;
    logic signed [31:0] m_cmd_value;
    logic               m_addr_updated;
    logic               m_value_updated;
    logic               m_frame_error;

    frame_scoreboard    sb = new();

    // Bytes of the frame being built, sent in order by send_frame.
    logic [7:0]         frame_bytes[$];
    int                 bytes_sent  = 0;
    int                 in_calm_left = 0;
    int                 cycles      = 0;

    bracket_command_frame_parser u_top (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_rx_byte       (s_rx_byte),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_cmd_addr      (m_cmd_addr),
        .m_cmd_value     (m_cmd_value),
        .m_addr_updated  (m_addr_updated),
        .m_value_updated (m_value_updated),
        .m_frame_error   (m_frame_error)
    );

    initial begin
        aclk = 1'b0;
        forever #10 aclk = ~aclk;
    end

    // Idle lengths: mostly none or short, now and then a long pause.
    function automatic int pick_idle();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 10);
        return $urandom_range(11, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Frame builders. Each one appends bytes to frame_bytes.
    // ------------------------------------------------------------------------

    // One of the six white space characters, with a plain space most often.
    function automatic logic [7:0] blank_char();
        int pick;
        pick = $urandom_range(0, 6);
        return (pick >= 5) ? 8'h20 : (8'h09 + 8'(pick));
    endfunction

    // Any byte except a bracket or a zero, so the frame stays open and clean.
    function automatic logic [7:0] junk_char();
        logic [7:0] c;
        do
            c = 8'($urandom_range(1, 255));
        while (c == CHAR_OPEN || c == CHAR_CLOSE);
        return c;
    endfunction

    function automatic void add_text(string s);
        for (int i = 0; i < s.len(); i++)
            frame_bytes.push_back(s[i]);
    endfunction

    function automatic void add_blanks(int most);
        int n;
        n = $urandom_range(0, most);
        repeat (n) frame_bytes.push_back(blank_char());
    endfunction

    // A signed decimal number. The magnitudes lean toward the saturation
    // points: exactly 2^31 - 1 and 2^31, their neighbors, full 32-bit
    // values and digit strings far past the 32-bit range.
    function automatic void add_number();
        int              sign_pick;
        int              kind;
        int              n;
        longint unsigned mag;
        sign_pick = $urandom_range(0, 3);
        if (sign_pick == 1)
            frame_bytes.push_back(CHAR_PLUS);
        else if (sign_pick >= 2)
            frame_bytes.push_back(CHAR_MINUS);
        kind = $urandom_range(0, 9);
        if (kind == 8) begin
            n = $urandom_range(10, 20);
            frame_bytes.push_back(8'h31 + 8'($urandom_range(0, 8)));
            repeat (n) frame_bytes.push_back(8'h30 + 8'($urandom_range(0, 9)));
        end else begin
            case (kind)
                0, 1, 2, 3: mag = 64'($urandom_range(0, 999));
                4:          mag = 64'd2147483647;
                5:          mag = 64'd2147483648;
                6:          mag = 64'd2147483645 + 64'($urandom_range(0, 5));
                7:          mag = 64'($urandom());
                default: begin
                    // Leading zeros must not disturb the value.
                    add_text("00");
                    mag = 64'($urandom_range(0, 99));
                end
            endcase
            add_text($sformatf("%0d", mag));
        end
    endfunction

    // A frame that mostly matches the pattern; some shapes break it after the
    // first number so that only the address is taken.
    function automatic void build_command_frame();
        int shape;
        int n;
        frame_bytes.push_back(CHAR_OPEN);
        add_blanks(2);
        add_number();
        shape = $urandom_range(0, 19);
        if (shape < 13) begin
            frame_bytes.push_back(CHAR_COMMA);
            add_blanks(2);
            add_number();
            // Bytes after the second number are ignored until the close, but a digit right after it extends the number.
            if ($urandom_range(0, 3) == 0) begin
                n = $urandom_range(1, 4);
                repeat (n) frame_bytes.push_back(junk_char());
            end
        end else if (shape == 15) begin
            // White space before the comma ends the match after the address.
            frame_bytes.push_back(blank_char());
            frame_bytes.push_back(CHAR_COMMA);
            add_number();
        end else if (shape == 16) begin
            frame_bytes.push_back(CHAR_COMMA);
            add_blanks(2);
            if ($urandom_range(0, 1) == 1)
                frame_bytes.push_back($urandom_range(0, 1) ? CHAR_PLUS : CHAR_MINUS);
        end else if (shape > 16) begin
            frame_bytes.push_back(CHAR_COMMA);
            add_blanks(1);
            frame_bytes.push_back(junk_char());
        end
        // Shapes 13 and 14 close right after the first number.
        frame_bytes.push_back(CHAR_CLOSE);
    endfunction

    // Fully random bytes, zeros and brackets included.
    function automatic void build_noise_frame();
        int n;
        frame_bytes.push_back(CHAR_OPEN);
        n = $urandom_range(0, 8);
        repeat (n) frame_bytes.push_back(8'($urandom_range(0, 255)));
        frame_bytes.push_back(CHAR_CLOSE);
    endfunction

    // Total lengths straddle the 64-byte limit so both sides of it are seen.
    function automatic void build_long_frame();
        int total;
        total = $urandom_range(60, 68);
        frame_bytes.push_back(CHAR_OPEN);
        add_number();
        frame_bytes.push_back(CHAR_COMMA);
        add_number();
        while (frame_bytes.size() < total - 1)
            frame_bytes.push_back(($urandom_range(0, 1) == 1) ? blank_char() : junk_char());
        frame_bytes.push_back(CHAR_CLOSE);
    endfunction

    // Loose bytes between frames, sometimes with a stray close.
    function automatic void build_outside();
        int n;
        n = $urandom_range(1, 4);
        repeat (n) frame_bytes.push_back(junk_char());
        if ($urandom_range(0, 1) == 1)
            frame_bytes.push_back(CHAR_CLOSE);
    endfunction

    // ------------------------------------------------------------------------
    // Input channel. Every byte may be preceded by a random idle stretch, and
    // once in a while a run of bytes goes out back to back. A beat counts as
    // accepted at the edge where valid and ready were both high; ready is
    // read right after the edge, before any register in the block updates.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (in_calm_left > 0) begin
            in_calm_left--;
            gap = 0;
        end else begin
            gap = pick_idle();
            if ($urandom_range(0, 199) == 0)
                in_calm_left = $urandom_range(40, 160);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_rx_byte <= b;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame();
        foreach (frame_bytes[i])
            send_byte(frame_bytes[i]);
        frame_bytes.delete();
    endtask

    // ------------------------------------------------------------------------
    // Result channel. Ready stalls at random, with occasional long stretches
    // of steady ready. Each accepted beat is checked against the oldest
    // command the predictor has queued.
    // ------------------------------------------------------------------------
    initial begin : result_sink
        int       stall_left;
        int       calm_left;
        command_t got;
        stall_left = 0;
        calm_left  = 0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready) begin
                got.addr          = m_cmd_addr;
                got.value         = m_cmd_value;
                got.addr_updated  = m_addr_updated;
                got.value_updated = m_value_updated;
                got.frame_error   = m_frame_error;
                sb.check_result(got);
            end
            if (calm_left > 0) begin
                calm_left--;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 3) == 0)
                    stall_left = pick_idle();
                if ($urandom_range(0, 499) == 0)
                    calm_left = $urandom_range(50, 300);
            end
        end
    end

    // A hung handshake ends the run here.
    initial begin : watchdog
        while (cycles < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycles++;
        end
        $display("ERROR: no progress after %0d cycles", CYCLE_LIMIT);
        $display("Simulation FAILED");
        $finish;
    end

    initial begin : stimulus
        int roll;
        int directed_bytes;
        int failures;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed opening. A loose byte and a stray close give no result. A
        // second open restarts the frame, and bytes after a full match are
        // skipped. A lone first number sets only the address; a sign with no
        // digits matches nothing. A zero byte rejects the frame, and a top-bit
        // byte right after the open fails the match.
        add_text("q]");
        add_text("[[4,-5 x]");
        add_text("[+7]");
        add_text("[ \t-]");
        add_text("[3,");
        frame_bytes.push_back(CHAR_NUL);
        frame_bytes.push_back(CHAR_CLOSE);
        frame_bytes.push_back(CHAR_OPEN);
        frame_bytes.push_back(8'hFF);
        frame_bytes.push_back(CHAR_CLOSE);
        send_frame();
        directed_bytes = bytes_sent;

        // Random part: mostly well-formed commands with random numbers, mixed with
        // restarted frames, random garbage, overlong frames and loose bytes.
        while (bytes_sent < directed_bytes + RANDOM_BYTES) begin
            roll = $urandom_range(0, 99);
            if (roll < 65) begin
                build_command_frame();
            end else if (roll < 75) begin
                frame_bytes.push_back(CHAR_OPEN);
                add_number();
                build_command_frame();
            end else if (roll < 87) begin
                build_noise_frame();
            end else if (roll < 92) begin
                build_long_frame();
            end else begin
                build_outside();
            end
            send_frame();
        end
        s_valid <= 1'b0;

        // Let every queued command come back, then watch a little longer for
        // any beat that should not be there.
        while (sb.pending() > 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        failures = sb.mismatches + sb.pending();
        if (sb.pending() > 0)
            $display("ERROR: %0d closed frames never produced a result", sb.pending());
        if (sb.mismatches > 10)
            $display("Further mismatches not shown: %0d in total", sb.mismatches);
        $display("Run covered %0d bytes (%0d directed) in %0d cycles.",
                 bytes_sent, directed_bytes, cycles);
        $display({"Closed frames: %0d full commands, %0d address only, ",
                  "%0d unmatched, %0d rejected."},
                 sb.full_commands, sb.addr_only, sb.unmatched, sb.rejects);
        if (failures == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

`default_nettype wire
